// ===== design/mpsm_pkg.sv =====
// Shared types and constants for the multi-pattern span marker.
// Holds sizes, codes, the controller state type and the command/status bundles.
// No dependencies.
package mpsm_pkg;

  localparam int MAX_PATTERNS    = 4;
  localparam int MAX_PATTERN_LEN = 16;

  localparam int SLOT_W   = 2;                                   // slot field width
  localparam int POS_W    = 4;                                   // position field width
  localparam int LEN_W    = 5;                                   // length register width
  localparam int CNT_W    = 3;                                   // pattern_count width
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 2;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 3;                                   // config index width
  localparam int PEND_W   = $clog2(MAX_PATTERN_LEN + 1);         // pending count
  localparam int WIN_W    = $clog2(MAX_PATTERN_LEN);             // window index
  localparam int SCNT_W   = $clog2(MAX_PATTERNS + 1);            // slot scan counter
  localparam int SIDX_W   = $clog2(MAX_PATTERNS);                // slot index
  localparam int ADDR_W   = SIDX_W + WIN_W;
  localparam int STORE_DEPTH = MAX_PATTERNS * MAX_PATTERN_LEN;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

  localparam logic [IDX_W-1:0] REG_COUNT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEN_ZERO  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LEN_ONE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_LEN_TWO   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LEN_THREE = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_READ,
    ST_MARK,
    ST_REL,
    ST_FEND
  } state_t;

  typedef struct packed {
    logic capture;         // take the input item this cycle
    logic scan_init;       // restart the slot scan
    logic slot_skip;       // step past an ineligible slot
    logic slot_begin;      // start comparing the current slot
    logic read_issue;      // read one pattern byte
    logic mark_apply;      // finish the slot, mark on a hit
    logic rel_init_text;   // release the oldest window byte
    logic rel_init_flush;  // release every held byte
    logic emit_marker;
    logic emit_byte;
    logic emit_close_last;
    logic emit_empty_last;
    logic clear_text;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic slot_done;
    logic slot_ok;
    logic k_last;
    logic pending_full;
    logic pending_zero;
    logic rel_differs;
    logic rel_zero;
    logic span_open;
    logic flushing;
  } dp_status_t;

endpackage

// ===== design/mpsm_datapath.sv =====
// Datapath of the multi-pattern span marker: window, marks, pattern memory,
// config registers, compare logic and the output register.
// Depends on mpsm_pkg; driven by commands from mpsm_ctrl.
module mpsm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  mpsm_pkg::dp_cmd_t               cmd,
  output mpsm_pkg::dp_status_t            status,
  input  logic [mpsm_pkg::MODE_W-1:0]     mode,
  input  logic [mpsm_pkg::SLOT_W-1:0]     slot,
  input  logic [mpsm_pkg::POS_W-1:0]      position,
  input  logic [mpsm_pkg::BYTE_W-1:0]     value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpsm_pkg::IDX_W-1:0]      cfg_index,
  input  logic [mpsm_pkg::LEN_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mpsm_pkg::KIND_W-1:0]     kind,
  output logic [mpsm_pkg::BYTE_W-1:0]     char_out,
  output logic                            last
);

  logic [mpsm_pkg::BYTE_W-1:0]          window [mpsm_pkg::MAX_PATTERN_LEN];
  logic [mpsm_pkg::MAX_PATTERN_LEN-1:0] marks;
  logic [mpsm_pkg::PEND_W-1:0]          pending;
  logic                                 span_open;
  logic                                 flushing;
  logic [mpsm_pkg::WIN_W-1:0]           rel_idx;

  logic [mpsm_pkg::CNT_W-1:0]           pattern_count;
  logic [mpsm_pkg::LEN_W-1:0]           lengths [mpsm_pkg::MAX_PATTERNS];

  logic [mpsm_pkg::BYTE_W-1:0]          store [mpsm_pkg::STORE_DEPTH];
  logic [mpsm_pkg::BYTE_W-1:0]          rdata;
  logic [mpsm_pkg::SCNT_W-1:0]          slot_cnt;
  logic [mpsm_pkg::WIN_W-1:0]           k;
  logic [mpsm_pkg::WIN_W-1:0]           cmp_idx;
  logic                                 cmp_valid;
  logic                                 hit_acc;

  logic [mpsm_pkg::CNT_W-1:0]           cnt_eff;
  logic [mpsm_pkg::LEN_W-1:0]           cur_len;
  logic [mpsm_pkg::LEN_W-1:0]           len_m1;
  logic                                 match_now;
  logic                                 hit_final;
  logic [mpsm_pkg::MAX_PATTERN_LEN-1:0] len_mask;
  logic                                 rel_mark;
  logic                                 any_emit;
  logic [mpsm_pkg::ADDR_W-1:0]          rd_addr;

  assign cfg_ready = 1'b1;

  assign cnt_eff = (pattern_count > mpsm_pkg::CNT_W'(mpsm_pkg::MAX_PATTERNS))
                   ? mpsm_pkg::CNT_W'(mpsm_pkg::MAX_PATTERNS) : pattern_count;
  assign cur_len   = lengths[slot_cnt[mpsm_pkg::SIDX_W-1:0]];
  assign len_m1    = cur_len - mpsm_pkg::LEN_W'(1);
  assign match_now = (rdata == window[cmp_idx]);
  assign hit_final = hit_acc && match_now;
  assign rel_mark  = marks[rel_idx];
  assign rd_addr   = {slot_cnt[mpsm_pkg::SIDX_W-1:0], k};
  assign any_emit  = cmd.emit_marker | cmd.emit_byte | cmd.emit_close_last |
                     cmd.emit_empty_last;

  always_comb begin
    for (int i = 0; i < mpsm_pkg::MAX_PATTERN_LEN; i++) begin
      len_mask[i] = (mpsm_pkg::LEN_W'(i) < cur_len);
    end
  end

  always_comb begin
    status.out_free     = !out_valid || !out_stall;
    status.slot_done    = (slot_cnt == mpsm_pkg::SCNT_W'(mpsm_pkg::MAX_PATTERNS));
    status.slot_ok      = (mpsm_pkg::CNT_W'(slot_cnt) < cnt_eff) &&
                          (cur_len != '0) &&
                          (cur_len <= mpsm_pkg::LEN_W'(mpsm_pkg::MAX_PATTERN_LEN)) &&
                          (mpsm_pkg::PEND_W'(cur_len) <= pending);
    status.k_last       = ({1'b0, k} == len_m1);
    status.pending_full = (pending == mpsm_pkg::PEND_W'(mpsm_pkg::MAX_PATTERN_LEN));
    status.pending_zero = (pending == '0);
    status.rel_differs  = (rel_mark != span_open);
    status.rel_zero     = (rel_idx == '0);
    status.span_open    = span_open;
    status.flushing     = flushing;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
      for (int i = 0; i < mpsm_pkg::MAX_PATTERNS; i++) lengths[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpsm_pkg::REG_COUNT:     pattern_count <= cfg_data[mpsm_pkg::CNT_W-1:0];
        mpsm_pkg::REG_LEN_ZERO:  lengths[0] <= cfg_data;
        mpsm_pkg::REG_LEN_ONE:   lengths[1] <= cfg_data;
        mpsm_pkg::REG_LEN_TWO:   lengths[2] <= cfg_data;
        mpsm_pkg::REG_LEN_THREE: lengths[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pattern memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.capture && mode == mpsm_pkg::MODE_LOAD &&
        int'(slot) < mpsm_pkg::MAX_PATTERNS &&
        int'(position) < mpsm_pkg::MAX_PATTERN_LEN) begin
      store[{slot[mpsm_pkg::SIDX_W-1:0], position[mpsm_pkg::WIN_W-1:0]}] <= value;
    end
    if (cmd.read_issue) begin
      rdata <= store[rd_addr];
    end
  end

  // scan counters and compare
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt  <= '0;
      k         <= '0;
      cmp_valid <= 1'b0;
      hit_acc   <= 1'b0;
      cmp_idx   <= '0;
    end else begin
      cmp_valid <= cmd.read_issue;
      if (cmd.scan_init) begin
        slot_cnt <= '0;
      end else if (cmd.slot_skip || cmd.mark_apply) begin
        slot_cnt <= slot_cnt + mpsm_pkg::SCNT_W'(1);
      end
      if (cmd.slot_begin) begin
        k       <= '0;
        hit_acc <= 1'b1;
      end else begin
        if (cmp_valid && !match_now) hit_acc <= 1'b0;
        if (cmd.read_issue) begin
          k       <= k + mpsm_pkg::WIN_W'(1);
          cmp_idx <= mpsm_pkg::WIN_W'(len_m1 - {1'b0, k});
        end
      end
    end
  end

  // window, marks, span state and output register
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_text) begin
      for (int i = 0; i < mpsm_pkg::MAX_PATTERN_LEN; i++) window[i] <= '0;
      marks     <= '0;
      pending   <= '0;
      span_open <= 1'b0;
    end else begin
      if (cmd.capture && mode == mpsm_pkg::MODE_TEXT) begin
        for (int i = mpsm_pkg::MAX_PATTERN_LEN - 1; i > 0; i--) window[i] <= window[i-1];
        window[0] <= value;
        marks     <= {marks[mpsm_pkg::MAX_PATTERN_LEN-2:0], 1'b0};
        if (!status.pending_full) pending <= pending + mpsm_pkg::PEND_W'(1);
      end
      if (cmd.mark_apply && hit_final) begin
        marks <= marks | len_mask;
      end
      if (cmd.emit_marker) begin
        span_open <= !span_open;
      end
      if (cmd.emit_byte && !flushing) begin
        pending <= mpsm_pkg::PEND_W'(mpsm_pkg::MAX_PATTERN_LEN - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
      rel_idx  <= '0;
    end else begin
      if (cmd.rel_init_text) begin
        flushing <= 1'b0;
        rel_idx  <= mpsm_pkg::WIN_W'(mpsm_pkg::MAX_PATTERN_LEN - 1);
      end else if (cmd.rel_init_flush) begin
        flushing <= 1'b1;
        rel_idx  <= mpsm_pkg::WIN_W'(pending - mpsm_pkg::PEND_W'(1));
      end else if (cmd.emit_byte && flushing) begin
        rel_idx  <= rel_idx - mpsm_pkg::WIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (any_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_marker) begin
      kind     <= span_open ? mpsm_pkg::KIND_CLOSE : mpsm_pkg::KIND_OPEN;
      char_out <= '0;
      last     <= 1'b0;
    end else if (cmd.emit_byte) begin
      kind     <= mpsm_pkg::KIND_BYTE;
      char_out <= window[rel_idx];
      last     <= flushing && status.rel_zero && !span_open;
    end else if (cmd.emit_close_last) begin
      kind     <= mpsm_pkg::KIND_CLOSE;
      char_out <= '0;
      last     <= 1'b1;
    end else if (cmd.emit_empty_last) begin
      kind     <= mpsm_pkg::KIND_EMPTY;
      char_out <= '0;
      last     <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending <= mpsm_pkg::PEND_W'(mpsm_pkg::MAX_PATTERN_LEN))
    else $error("pending count beyond window depth");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    any_emit |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_marker, cmd.emit_byte, cmd.emit_close_last, cmd.emit_empty_last}))
    else $error("two results loaded in one cycle");

  a_text_release: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_byte && !flushing) |=>
      pending == mpsm_pkg::PEND_W'(mpsm_pkg::MAX_PATTERN_LEN - 1))
    else $error("text release did not drop pending count");
`endif

endmodule

// ===== design/mpsm_ctrl.sv =====
// Controller of the multi-pattern span marker: sequences capture, slot scan,
// byte release and end-of-text flush. Depends on mpsm_pkg; drives mpsm_datapath.
module mpsm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mpsm_pkg::MODE_W-1:0] mode,
  input  mpsm_pkg::dp_status_t        status,
  output mpsm_pkg::dp_cmd_t           cmd
);

  mpsm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      mpsm_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          case (mode)
            mpsm_pkg::MODE_TEXT: begin
              cmd.scan_init = 1'b1;
              state_next    = mpsm_pkg::ST_SLOT;
            end
            mpsm_pkg::MODE_END: begin
              if (status.pending_zero) begin
                state_next = mpsm_pkg::ST_FEND;
              end else begin
                cmd.rel_init_flush = 1'b1;
                state_next         = mpsm_pkg::ST_REL;
              end
            end
            default: ;  // loads finish in the datapath, unknown modes drop
          endcase
        end
      end
      mpsm_pkg::ST_SLOT: begin
        if (status.slot_done) begin
          if (status.pending_full) begin
            cmd.rel_init_text = 1'b1;
            state_next        = mpsm_pkg::ST_REL;
          end else begin
            state_next = mpsm_pkg::ST_IDLE;
          end
        end else if (status.slot_ok) begin
          cmd.slot_begin = 1'b1;
          state_next     = mpsm_pkg::ST_READ;
        end else begin
          cmd.slot_skip = 1'b1;
        end
      end
      mpsm_pkg::ST_READ: begin
        cmd.read_issue = 1'b1;
        if (status.k_last) state_next = mpsm_pkg::ST_MARK;
      end
      mpsm_pkg::ST_MARK: begin
        cmd.mark_apply = 1'b1;
        state_next     = mpsm_pkg::ST_SLOT;
      end
      mpsm_pkg::ST_REL: begin
        if (status.out_free) begin
          if (status.rel_differs) begin
            cmd.emit_marker = 1'b1;
          end else begin
            cmd.emit_byte = 1'b1;
            if (!status.flushing) begin
              state_next = mpsm_pkg::ST_IDLE;
            end else if (status.rel_zero) begin
              state_next = mpsm_pkg::ST_FEND;
            end
          end
        end
      end
      mpsm_pkg::ST_FEND: begin
        if (status.span_open || status.pending_zero) begin
          if (status.out_free) begin
            cmd.emit_close_last = status.span_open;
            cmd.emit_empty_last = !status.span_open;
            cmd.clear_text      = 1'b1;
            state_next          = mpsm_pkg::ST_IDLE;
          end
        end else begin
          cmd.clear_text = 1'b1;
          state_next     = mpsm_pkg::ST_IDLE;
        end
      end
      default: state_next = mpsm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/multi_pattern_span_marker.sv =====
// Multi-pattern span marker: up to four dictionary patterns of up to 16 bytes
// are loaded one byte per item; text bytes stream through a 16-byte window and
// every byte covered by a pattern occurrence is wrapped in open/close span
// results. A load item is written straight into the pattern memory. A text
// byte enters the window, then each slot is skipped or compared byte by byte
// (the pattern memory gives one byte per cycle); once the window is full the
// oldest byte is released, after an open/close result if its marking differs.
// End of text releases every held byte the same way and ends on a last result
// (final byte, close or empty). Output stalls delay the release; a finished
// result waits in the output register while the next item enters.
// Depends on mpsm_pkg, mpsm_ctrl and mpsm_datapath.
module multi_pattern_span_marker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mpsm_pkg::MODE_W-1:0] mode,
  input  logic [mpsm_pkg::SLOT_W-1:0] slot,
  input  logic [mpsm_pkg::POS_W-1:0]  position,
  input  logic [mpsm_pkg::BYTE_W-1:0] value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mpsm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mpsm_pkg::LEN_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mpsm_pkg::KIND_W-1:0] kind,
  output logic [mpsm_pkg::BYTE_W-1:0] char_out,
  output logic                        last
);

  mpsm_pkg::dp_cmd_t    cmd;
  mpsm_pkg::dp_status_t status;

  mpsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd)
  );

  mpsm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .mode      (mode),
    .slot      (slot),
    .position  (position),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .char_out  (char_out),
    .last      (last)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for multi_pattern_span_marker: loads patterns, streams text and flushes,
// and checks every result against a behavioral predictor held in a small scoreboard class.
// Depends on mpsm_pkg and the multi_pattern_span_marker RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpsm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_START = 2500;   // cycles between long output hold-offs
  localparam int HOLD_LEN   = 400;
  localparam int TEXT_GOAL  = 350;

  typedef struct {
    kind_t            kind;
    logic [BYTE_W-1:0] ch;
    logic             last;
  } span_result_t;

  class span_scoreboard;
    logic [BYTE_W-1:0] window [MAX_PATTERN_LEN];
    bit                marks  [MAX_PATTERN_LEN];
    int unsigned       held;
    bit                span_open;
    logic [BYTE_W-1:0] pattern_store [STORE_DEPTH];
    int unsigned       pattern_total;
    int unsigned       lens [4];
    span_result_t      expected_q [$];
    int                errors;

    function new();
      foreach (pattern_store[i]) pattern_store[i] = '0;
      foreach (lens[i]) lens[i] = 0;
      pattern_total = 0;
      errors = 0;
      drop_text();
    endfunction

    function void drop_text();
      foreach (window[i]) begin
        window[i] = '0;
        marks[i]  = 1'b0;
      end
      held = 0;
      span_open = 1'b0;
    endfunction

    function void push(kind_t k, logic [BYTE_W-1:0] ch);
      span_result_t r;
      r.kind = k;
      r.ch   = ch;
      r.last = 1'b0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Emit a marker when the marking changes, then the byte itself.
    function void release_byte(logic [BYTE_W-1:0] ch, bit marked);
      if (marked && !span_open) begin
        push(KIND_OPEN, '0);
        span_open = 1'b1;
      end else if (!marked && span_open) begin
        push(KIND_CLOSE, '0);
        span_open = 1'b0;
      end
      push(KIND_BYTE, ch);
    endfunction

    function void note_config(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      case (idx)
        REG_COUNT:     pattern_total = data[CNT_W-1:0];
        REG_LEN_ZERO:  lens[0] = data;
        REG_LEN_ONE:   lens[1] = data;
        REG_LEN_TWO:   lens[2] = data;
        REG_LEN_THREE: lens[3] = data;
        default: ;
      endcase
    endfunction

    function void note_input(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] s,
                             logic [POS_W-1:0] p, logic [BYTE_W-1:0] v);
      int unsigned  lim;
      int unsigned  len;
      int           before_n;
      bit           hit;
      case (m)
        MODE_LOAD: pattern_store[s * MAX_PATTERN_LEN + p] = v;
        MODE_TEXT: begin
          for (int i = MAX_PATTERN_LEN - 1; i > 0; i--) begin
            window[i] = window[i-1];
            marks[i]  = marks[i-1];
          end
          window[0] = v;
          marks[0]  = 1'b0;
          if (held < MAX_PATTERN_LEN) held++;
          lim = (pattern_total > MAX_PATTERNS) ? MAX_PATTERNS : pattern_total;
          for (int sl = 0; sl < lim; sl++) begin
            len = lens[sl];
            if (len == 0 || len > MAX_PATTERN_LEN || len > held) continue;
            hit = 1'b1;
            for (int k = 0; k < len; k++)
              if (pattern_store[sl * MAX_PATTERN_LEN + k] != window[len - 1 - k]) hit = 1'b0;
            if (hit)
              for (int k = 0; k < len; k++) marks[k] = 1'b1;
          end
          if (held == MAX_PATTERN_LEN) begin
            release_byte(window[MAX_PATTERN_LEN-1], marks[MAX_PATTERN_LEN-1]);
            held = MAX_PATTERN_LEN - 1;
          end
        end
        MODE_END: begin
          before_n = expected_q.size();
          for (int i = int'(held) - 1; i >= 0; i--) release_byte(window[i], marks[i]);
          if (span_open) begin
            push(KIND_CLOSE, '0);
            span_open = 1'b0;
          end
          if (expected_q.size() == before_n) push(KIND_EMPTY, '0);
          expected_q[expected_q.size() - 1].last = 1'b1;
          drop_text();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] ch, logic lst);
      span_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d char=%02h last=%0b", $time, k, ch, lst);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (k !== exp_r.kind) begin
        $display("%0t: kind mismatch expected %0d actual %0d", $time, exp_r.kind, k);
        errors++;
      end
      if (ch !== exp_r.ch) begin
        $display("%0t: char_out mismatch expected %02h actual %02h", $time, exp_r.ch, ch);
        errors++;
      end
      if (lst !== exp_r.last) begin
        $display("%0t: last mismatch expected %0b actual %0b", $time, exp_r.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   slot;
  logic [POS_W-1:0]    position;
  logic [BYTE_W-1:0]   value;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [LEN_W-1:0]    cfg_data;
  logic                out_valid;
  logic                out_stall;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_char;
  logic                out_last;

  span_scoreboard sb = new();

  int  burst_left  = 0;
  bit  steady_feed = 1'b0;
  int  text_items  = 0;

  multi_pattern_span_marker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .slot      (slot),
    .position  (position),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (out_kind),
    .char_out  (out_char),
    .last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: changing stall styles, plus a long hold-off now and then.
  initial begin : stall_gen
    int style;
    int left;
    int since_hold;
    out_stall  = 1'b0;
    style      = 0;
    left       = 0;
    since_hold = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(20, 300);
      end
      left--;
      since_hold++;
      if (since_hold >= HOLD_START) begin
        out_stall <= 1'b1;
        if (since_hold >= HOLD_START + HOLD_LEN) since_hold = 0;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((left % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_kind, out_char, out_last);
  end

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                           input logic [POS_W-1:0] p, input logic [BYTE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= m;
    slot     <= s;
    position <= p;
    value    <= v;
    do @(posedge clk); while (in_stall);
    sb.note_input(m, s, p, v);
    if (m == MODE_TEXT || m == MODE_END) text_items++;
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  // Drop valid, drain every expected result, then let the block finish its cleanup.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic configure(input int cnt, input int l0, input int l1, input int l2,
                           input int l3);
    cfg_write(REG_COUNT, LEN_W'(cnt));
    cfg_write(REG_LEN_ZERO, LEN_W'(l0));
    cfg_write(REG_LEN_ONE, LEN_W'(l1));
    cfg_write(REG_LEN_TWO, LEN_W'(l2));
    cfg_write(REG_LEN_THREE, LEN_W'(l3));
    if ($urandom_range(0, 2) == 0)
      cfg_write(IDX_W'(REG_LEN_THREE + $urandom_range(1, 3)), LEN_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 4);
    if (r < 14) return 0;
    if (r < 16) return MAX_PATTERN_LEN;
    if (r < 18) return $urandom_range(5, 15);
    return $urandom_range(17, 31);
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_byte();
    if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom);
    return BYTE_W'(8'h61 + $urandom_range(0, 1));
  endfunction

  task automatic load_patterns();
    int len;
    for (int sl = 0; sl < MAX_PATTERNS; sl++) begin
      if ($urandom_range(0, 1) == 0) continue;
      len = (sb.lens[sl] > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : sb.lens[sl];
      for (int p = 0; p < len; p++)
        send_item(MODE_LOAD, SLOT_W'(sl), POS_W'(p), pattern_byte());
    end
  endtask

  // Stream one text, splicing in copies of live patterns so matches really happen.
  task automatic run_text(input int nbytes);
    int i;
    int sl;
    int len;
    int lim;
    int r;
    i = 0;
    lim = (sb.pattern_total > MAX_PATTERNS) ? MAX_PATTERNS : sb.pattern_total;
    while (i < nbytes) begin
      r = $urandom_range(0, 59);
      if (r < 10 && lim > 0) begin
        sl  = $urandom_range(0, lim - 1);
        len = sb.lens[sl];
        if (len >= 1 && len <= MAX_PATTERN_LEN) begin
          for (int k = 0; k < len; k++)
            send_item(MODE_TEXT, SLOT_W'($urandom), POS_W'($urandom),
                      sb.pattern_store[sl * MAX_PATTERN_LEN + k]);
          i += len;
        end
      end else if (r < 13) begin
        send_item(MODE_UNUSED, SLOT_W'($urandom), POS_W'($urandom), BYTE_W'($urandom));
      end else if (r < 15) begin
        send_item(MODE_LOAD, SLOT_W'($urandom), POS_W'($urandom), pattern_byte());
      end else begin
        if (r < 21)
          send_item(MODE_TEXT, SLOT_W'($urandom), POS_W'($urandom), BYTE_W'($urandom));
        else
          send_item(MODE_TEXT, SLOT_W'($urandom), POS_W'($urandom),
                    BYTE_W'(8'h61 + $urandom_range(0, 2)));
        i++;
      end
    end
    send_item(MODE_END, SLOT_W'($urandom), POS_W'($urandom), BYTE_W'($urandom));
  endtask

  initial begin : stimulus
    int phase;
    int ntexts;
    int r;
    int cnt;
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = MODE_LOAD;
    slot      = '0;
    position  = '0;
    value     = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COUNT;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the whole store first so no pattern in use ever reads an unwritten byte.
    for (int sl = 0; sl < MAX_PATTERNS; sl++)
      for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
        if (sl == 0 && p == 0)
          send_item(MODE_LOAD, SLOT_W'(sl), POS_W'(p), 8'hFF);
        else if (sl == 1)
          send_item(MODE_LOAD, SLOT_W'(sl), POS_W'(p), 8'h00);
        else
          send_item(MODE_LOAD, SLOT_W'(sl), POS_W'(p), pattern_byte());
      end

    // Directed: one-byte pattern, full-length pattern, empty and overlong slots.
    settle();
    configure(MAX_PATTERNS, 1, MAX_PATTERN_LEN, 0, MAX_PATTERN_LEN + 1);
    send_item(MODE_END, 2'd0, 4'd0, 8'h00);                // empty text
    send_item(MODE_UNUSED, 2'd3, 4'd15, 8'hFF);            // ignored
    send_item(MODE_TEXT, 2'd3, 4'd15, 8'hFF);
    send_item(MODE_END, 2'd3, 4'd15, 8'hFF);
    for (int k = 0; k < MAX_PATTERN_LEN; k++) send_item(MODE_TEXT, 2'd0, 4'd0, 8'h00);
    send_item(MODE_TEXT, 2'd1, 4'd7, 8'hFF);
    send_item(MODE_END, 2'd2, 4'd8, 8'h00);

    phase = 0;
    while (text_items < TEXT_GOAL) begin
      settle();
      steady_feed = (phase % 3 == 1);
      if (phase % 5 == 0) begin
        configure(MAX_PATTERNS, MAX_PATTERN_LEN, MAX_PATTERN_LEN, MAX_PATTERN_LEN,
                  MAX_PATTERN_LEN);
      end else begin
        cnt = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7);
        configure(cnt, pick_len(), pick_len(), pick_len(), pick_len());
      end
      load_patterns();
      ntexts = $urandom_range(3, 6);
      for (int t = 0; t < ntexts; t++) begin
        r = $urandom_range(0, 9);
        if (r == 0)     run_text(0);
        else if (r < 8) run_text($urandom_range(1, 20));
        else            run_text($urandom_range(21, 60));
      end
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mpsm_pkg.sv
design/mpsm_datapath.sv
design/mpsm_ctrl.sv
design/multi_pattern_span_marker.sv
tb/tb_top.sv
